### rtl/core/flog2_pkg.sv
// flog2_pkg: shared types, constants and single-precision arithmetic functions
// for the float log2 pipeline. No dependencies.
package flog2_pkg;

	typedef enum logic [3:0] {
		OP_REDUCE,
		OP_SUB1,
		OP_SQUARE,
		OP_HMUL,
		OP_HADD,
		OP_PX,
		OP_YZ,
		OP_YW,
		OP_RL,
		OP_XL,
		OP_RQ,
		OP_RY,
		OP_RX,
		OP_RE
	} flog2_op_t;

	// operands carried down the pipe
	typedef struct packed {
		logic [31:0]       x;
		logic [31:0]       z;
		logic [31:0]       p;
		logic [31:0]       y;
		logic [31:0]       w;
		logic [31:0]       q;
		logic [31:0]       r;
		logic [31:0]       ef;
		logic signed [8:0] e;
	} flog2_item_t;

	localparam int NUM_COEF   = 9;
	localparam int NUM_STAGES = 3 + 2 * (NUM_COEF - 1) + 9;

	localparam logic [31:0] KEEP_SIGN_MANT = 32'h807f_ffff;
	localparam logic [31:0] HALF_EXP_BITS  = 32'h3f00_0000;
	localparam logic [8:0]  EXP_BIAS_LESS1 = 9'h07e;
	localparam logic [31:0] MINUS_ONE      = 32'hbf80_0000;

	// round a double-precision pattern to single precision, nearest even
	function automatic logic [31:0] f64_to_f32(input logic [63:0] d);
		logic [10:0] ex;
		logic [23:0] mr;
		logic        inc;
		ex  = d[62:52] - 11'd1023 + 11'd127;
		inc = d[28] & ((|d[27:0]) | d[29]);
		mr  = {1'b0, d[51:29]} + {23'b0, inc};
		if (mr[23]) begin
			ex = ex + 11'd1;
		end
		return {d[63], ex[7:0], mr[23] ? 23'b0 : mr[22:0]};
	endfunction

	localparam logic [31:0] SQRT_HALF = f64_to_f32($realtobits(0.707106781186547524));
	localparam logic [31:0] LOG2E_M1  = f64_to_f32($realtobits(0.44269504088896340735992));

	localparam logic [31:0] POLY_COEF [NUM_COEF] = '{
		f64_to_f32($realtobits(7.0376836292E-2)),
		f64_to_f32($realtobits(-1.1514610310E-1)),
		f64_to_f32($realtobits(1.1676998740E-1)),
		f64_to_f32($realtobits(-1.2420140846E-1)),
		f64_to_f32($realtobits(1.4249322787E-1)),
		f64_to_f32($realtobits(-1.6668057665E-1)),
		f64_to_f32($realtobits(2.0000714765E-1)),
		f64_to_f32($realtobits(-2.4999993993E-1)),
		f64_to_f32($realtobits(3.3333331174E-1))
	};

	// single-precision product, zero and normal operands, round to nearest even
	function automatic logic [31:0] fp_mul(input logic [31:0] a, input logic [31:0] b);
		logic [47:0]       pr;
		logic [22:0]       mt;
		logic              g;
		logic              st;
		logic [23:0]       mr;
		logic signed [9:0] ex;
		logic [31:0]       res;
		if (a[30:23] == 8'd0 || b[30:23] == 8'd0) begin
			res = {a[31] ^ b[31], 31'b0};
		end else begin
			pr = {1'b1, a[22:0]} * {1'b1, b[22:0]};
			ex = signed'({2'b0, a[30:23]}) + signed'({2'b0, b[30:23]}) - 10'sd127;
			if (pr[47]) begin
				mt = pr[46:24];
				g  = pr[23];
				st = |pr[22:0];
				ex = ex + 10'sd1;
			end else begin
				mt = pr[45:23];
				g  = pr[22];
				st = |pr[21:0];
			end
			mr = {1'b0, mt} + {23'b0, g & (st | mt[0])};
			if (mr[23]) begin
				ex = ex + 10'sd1;
			end
			res = {a[31] ^ b[31], ex[7:0], mr[23] ? 23'b0 : mr[22:0]};
		end
		return res;
	endfunction

	// single-precision sum, zero and normal operands, round to nearest even
	function automatic logic [31:0] fp_add(input logic [31:0] a, input logic [31:0] b);
		logic [31:0]       hi;
		logic [31:0]       lo;
		logic [7:0]        d;
		logic [26:0]       mh;
		logic [26:0]       ml;
		logic [26:0]       sh;
		logic [26:0]       msk;
		logic [27:0]       sm;
		logic [26:0]       nm;
		logic [4:0]        lz;
		logic              found;
		logic signed [9:0] ex;
		logic [24:0]       mr;
		logic [31:0]       res;
		if (a[30:23] == 8'd0 && b[30:23] == 8'd0) begin
			res = {a[31] & b[31], 31'b0};
		end else if (a[30:23] == 8'd0) begin
			res = b;
		end else if (b[30:23] == 8'd0) begin
			res = a;
		end else begin
			if (a[30:0] < b[30:0]) begin
				hi = b;
				lo = a;
			end else begin
				hi = a;
				lo = b;
			end
			d  = hi[30:23] - lo[30:23];
			mh = {1'b1, hi[22:0], 3'b0};
			ml = {1'b1, lo[22:0], 3'b0};
			if (d >= 8'd27) begin
				sh = 27'd1;
			end else begin
				msk   = (27'd1 << d) - 27'd1;
				sh    = ml >> d;
				sh[0] = sh[0] | (|(ml & msk));
			end
			if (hi[31] ^ lo[31]) begin
				sm = {1'b0, mh} - {1'b0, sh};
			end else begin
				sm = {1'b0, mh} + {1'b0, sh};
			end
			if (sm == 28'd0) begin
				res = 32'd0;
			end else begin
				if (sm[27]) begin
					nm = {sm[27:2], sm[1] | sm[0]};
					ex = signed'({2'b0, hi[30:23]}) + 10'sd1;
				end else begin
					lz    = 5'd0;
					found = 1'b0;
					for (int i = 26; i >= 0; i--) begin
						if (!found) begin
							if (sm[i]) begin
								found = 1'b1;
							end else begin
								lz = lz + 5'd1;
							end
						end
					end
					nm = sm[26:0] << lz;
					ex = signed'({2'b0, hi[30:23]}) - signed'({5'b0, lz});
				end
				mr = {1'b0, nm[26:3]} + {24'b0, nm[2] & (nm[1] | nm[0] | nm[3])};
				if (mr[24]) begin
					ex = ex + 10'sd1;
				end
				res = {hi[31], ex[7:0], mr[24] ? mr[23:1] : mr[22:0]};
			end
		end
		return res;
	endfunction

	// exact conversion of the small signed exponent to single precision
	function automatic logic [31:0] int_to_fp(input logic signed [8:0] e);
		logic [8:0]  ab;
		logic [7:0]  nm;
		logic [3:0]  lz;
		logic        found;
		logic [7:0]  ex;
		logic [31:0] res;
		if (e == 9'sd0) begin
			res = 32'd0;
		end else begin
			ab    = e[8] ? 9'(-e) : 9'(e);
			lz    = 4'd0;
			found = 1'b0;
			for (int i = 7; i >= 0; i--) begin
				if (!found) begin
					if (ab[i]) begin
						found = 1'b1;
					end else begin
						lz = lz + 4'd1;
					end
				end
			end
			nm  = ab[7:0] << lz;
			ex  = 8'd134 - {4'b0, lz};
			res = {e[8], ex, nm[6:0], 16'b0};
		end
		return res;
	endfunction

	// operation done by each stage of the pipe
	function automatic flog2_op_t stage_op(input int s);
		flog2_op_t op;
		if (s == 0) begin
			op = OP_REDUCE;
		end else if (s == 1) begin
			op = OP_SUB1;
		end else if (s == 2) begin
			op = OP_SQUARE;
		end else if (s < 3 + 2 * (NUM_COEF - 1)) begin
			op = ((s - 3) % 2 == 0) ? OP_HMUL : OP_HADD;
		end else begin
			case (s - (3 + 2 * (NUM_COEF - 1)))
				0: op = OP_PX;
				1: op = OP_YZ;
				2: op = OP_YW;
				3: op = OP_RL;
				4: op = OP_XL;
				5: op = OP_RQ;
				6: op = OP_RY;
				7: op = OP_RX;
				default: op = OP_RE;
			endcase
		end
		return op;
	endfunction

endpackage

### rtl/core/float_log2_unit.sv
// float_log2_unit: base-2 logarithm of a single-precision value, 28-stage pipeline.
// Throughput is one item per cycle while out_ready does not hold the pipe, set by
// one rounded multiply or add per stage. The whole pipe, bubbles included, holds
// while a result waits. Reset clears all stage valid bits; data is not reset.
// Depends on flog2_pkg and flog2_stage.
module float_log2_unit
	import flog2_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [31:0] value_bits,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [31:0] log2_bits
);

	logic        valid_s [NUM_STAGES + 1];
	flog2_item_t data_s  [NUM_STAGES + 1];
	logic        advance;

	assign advance   = !valid_s[NUM_STAGES] || out_ready;
	assign in_ready  = advance;
	assign out_valid = valid_s[NUM_STAGES];
	assign log2_bits = data_s[NUM_STAGES].r;

	assign valid_s[0] = in_valid;
	assign data_s[0]  = '{x: value_bits, default: '0};

	for (genvar s = 0; s < NUM_STAGES; s++) begin : g_stage
		flog2_stage #(
			.OP (stage_op(s)),
			.K  ((s >= 3) ? (s - 3) / 2 + 1 : 1)
		) u_stage (
			.clk       (clk),
			.arst_n    (arst_n),
			.advance   (advance),
			.in_valid  (valid_s[s]),
			.in_data   (data_s[s]),
			.out_valid (valid_s[s + 1]),
			.out_data  (data_s[s + 1])
		);
	end

endmodule

### rtl/core/flog2_stage.sv
// flog2_stage: one register stage of the log2 pipeline, doing one rounded
// single-precision operation. Depends on flog2_pkg.
module flog2_stage
	import flog2_pkg::*;
#(
	parameter flog2_op_t OP = OP_REDUCE,
	parameter int        K  = 1
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        advance,
	input  logic        in_valid,
	input  flog2_item_t in_data,
	output logic        out_valid,
	output flog2_item_t out_data
);

	flog2_item_t nxt;
	logic [31:0] mb;
	logic        below;

	always_comb begin
		nxt   = in_data;
		mb    = (in_data.x & KEEP_SIGN_MANT) | HALF_EXP_BITS;
		below = mb[31] || (mb[22:0] < SQRT_HALF[22:0]);
		unique case (OP)
			OP_REDUCE: begin
				nxt.e = signed'({1'b0, in_data.x[30:23]} - EXP_BIAS_LESS1);
				nxt.x = mb;
				if (below) begin
					// doubling is exact: bump the exponent field
					nxt.e = signed'({1'b0, in_data.x[30:23]} - EXP_BIAS_LESS1 - 9'd1);
					nxt.x = mb + 32'h0080_0000;
				end
				nxt.ef = int_to_fp(nxt.e);
			end
			OP_SUB1:   nxt.x = fp_add(in_data.x, MINUS_ONE);
			OP_SQUARE: begin
				nxt.z = fp_mul(in_data.x, in_data.x);
				nxt.p = POLY_COEF[0];
			end
			OP_HMUL:   nxt.p = fp_mul(in_data.p, in_data.x);
			OP_HADD:   nxt.p = fp_add(in_data.p, POLY_COEF[K]);
			OP_PX: begin
				nxt.p = fp_mul(in_data.p, in_data.x);
				// -0.5*z is exact: flip sign, drop exponent by one
				if (in_data.z[30:23] == 8'd0) begin
					nxt.w = {~in_data.z[31], 31'b0};
				end else begin
					nxt.w = {~in_data.z[31], in_data.z[30:23] - 8'd1, in_data.z[22:0]};
				end
			end
			OP_YZ:     nxt.y = fp_mul(in_data.p, in_data.z);
			OP_YW:     nxt.y = fp_add(in_data.y, in_data.w);
			OP_RL:     nxt.r = fp_mul(in_data.y, LOG2E_M1);
			OP_XL:     nxt.q = fp_mul(in_data.x, LOG2E_M1);
			OP_RQ:     nxt.r = fp_add(in_data.r, in_data.q);
			OP_RY:     nxt.r = fp_add(in_data.r, in_data.y);
			OP_RX:     nxt.r = fp_add(in_data.r, in_data.x);
			OP_RE:     nxt.r = fp_add(in_data.r, in_data.ef);
			default:   nxt = in_data;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (advance) begin
			out_valid <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			out_data <= nxt;
		end
	end

endmodule

### tb/float_log2_unit_chk.sv
// float_log2_unit_chk: watches both channels of float_log2_unit, predicts each
// log2 result in single precision and compares it with what comes out.
// Depends on nothing but the block's port widths.
`timescale 1ns / 100ps

module float_log2_unit_chk (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	input  logic        in_ready,
	input  logic [31:0] value_bits,
	input  logic        out_valid,
	input  logic        out_ready,
	input  logic [31:0] log2_bits,
	output int          errors,
	output int          pending
);

	localparam real SQRT_HALF_R = 0.707106781186547524;
	localparam real LOG2E_R     = 0.44269504088896340735992;
	localparam real COEF_R [9]  = '{
		7.0376836292E-2, -1.1514610310E-1, 1.1676998740E-1,
		-1.2420140846E-1, 1.4249322787E-1, -1.6668057665E-1,
		2.0000714765E-1, -2.4999993993E-1, 3.3333331174E-1
	};

	logic [31:0] log2_expected [$];

	// double to single, nearest even; values here are always zero or normal
	function automatic logic [31:0] to_single(input real v);
		logic [63:0] d;
		logic [24:0] man;
		int          ex;
		d = $realtobits(v);
		if (d[62:52] == 11'd0) begin
			return {d[63], 31'b0};
		end
		ex  = int'(d[62:52]) - 1023 + 127;
		man = {2'b01, d[51:29]} + {24'b0, d[28] & (d[29] | (|d[27:0]))};
		if (man[24]) begin
			ex  = ex + 1;
			man = man >> 1;
		end
		return {d[63], ex[7:0], man[22:0]};
	endfunction

	function automatic real to_real(input logic [31:0] f);
		if (f[30:23] == 8'd0) begin
			return $bitstoreal({f[31], 63'b0});
		end
		return $bitstoreal({f[31], 11'(f[30:23] + 11'd896), f[22:0], 29'b0});
	endfunction

	// products and sums of singles are exact or safely rounded in double
	function automatic logic [31:0] smul(input logic [31:0] a, input logic [31:0] b);
		return to_single(to_real(a) * to_real(b));
	endfunction

	function automatic logic [31:0] sadd(input logic [31:0] a, input logic [31:0] b);
		return to_single(to_real(a) + to_real(b));
	endfunction

	function automatic logic [31:0] predict_log2(input logic [31:0] v);
		int          e;
		logic [31:0] m;
		logic [31:0] x;
		logic [31:0] z;
		logic [31:0] p;
		logic [31:0] y;
		logic [31:0] r;
		logic [31:0] lg;
		e  = int'(v[30:23]) - 126;
		m  = {v[31], 8'h7e, v[22:0]};
		lg = to_single(LOG2E_R);
		if (to_real(m) < to_real(to_single(SQRT_HALF_R))) begin
			e = e - 1;
			x = sadd(sadd(m, m), to_single(-1.0));
		end else begin
			x = sadd(m, to_single(-1.0));
		end
		z = smul(x, x);
		p = to_single(COEF_R[0]);
		for (int i = 1; i < 9; i++) begin
			p = sadd(smul(p, x), to_single(COEF_R[i]));
		end
		y = smul(smul(p, x), z);
		y = sadd(y, smul(to_single(-0.5), z));
		r = smul(y, lg);
		r = sadd(r, smul(x, lg));
		r = sadd(r, y);
		r = sadd(r, x);
		r = sadd(r, to_single(real'(e)));
		return r;
	endfunction

	assign pending = log2_expected.size();

	initial begin
		errors = 0;
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if (in_valid && in_ready) begin
				log2_expected.push_back(predict_log2(value_bits));
			end
			if (out_valid && out_ready) begin
				if (log2_expected.size() == 0) begin
					$display("%0t: unexpected result transfer, actual %h", $time, log2_bits);
					errors = errors + 1;
				end else begin
					if (log2_bits !== log2_expected[0]) begin
						$display("%0t: log2_bits mismatch, expected %h actual %h",
							$time, log2_expected[0], log2_bits);
						errors = errors + 1;
					end
					void'(log2_expected.pop_front());
				end
			end
		end
	end

endmodule

### tb/float_log2_unit_tb.sv
// float_log2_unit_tb: drives operands into float_log2_unit with random gaps and
// back-pressure; float_log2_unit_chk does the prediction and comparison.
`timescale 1ns / 100ps

module float_log2_unit_tb;

	logic        clk;
	logic        arst_n;
	logic        in_valid;
	logic        in_ready;
	logic [31:0] value_bits;
	logic        out_valid;
	logic        out_ready;
	logic [31:0] log2_bits;
	int          errors;
	int          pending;
	logic        no_gaps;

	float_log2_unit dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.value_bits(value_bits),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.log2_bits (log2_bits)
	);

	float_log2_unit_chk chk (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.value_bits(value_bits),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.log2_bits (log2_bits),
		.errors    (errors),
		.pending   (pending)
	);

	initial begin
		clk = 1'b0;
		forever begin
			#1 clk = ~clk;
		end
	end

	// mostly short gaps, a few long ones
	function automatic int gap_len();
		int r;
		r = $urandom_range(0, 99);
		if (no_gaps || r < 45) begin
			return 0;
		end else if (r < 92) begin
			return $urandom_range(1, 3);
		end
		return $urandom_range(8, 40);
	endfunction

	task automatic send_operand(input logic [31:0] v);
		logic ok;
		@(negedge clk);
		repeat (gap_len()) begin
			in_valid <= 1'b0;
			@(negedge clk);
		end
		in_valid   <= 1'b1;
		value_bits <= v;
		forever begin
			#0.5 ok = in_ready;
			@(posedge clk);
			if (ok) begin
				break;
			end
			@(negedge clk);
		end
	endtask

	function automatic logic [31:0] random_operand();
		int r;
		r = $urandom_range(0, 9);
		if (r < 6) begin
			// positive normal, the intended operand range
			return {1'b0, 8'($urandom_range(1, 254)), 23'($urandom)};
		end else if (r < 7) begin
			// mantissa near the square-root-of-half split
			return {1'b0, 8'($urandom_range(1, 254)), 23'(32'h3504f3 + $urandom_range(0, 16) - 8)};
		end
		return $urandom;
	endfunction

	initial begin
		out_ready = 1'b0;
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			out_ready <= 1'b1;
			repeat ($urandom_range(1, 12)) @(negedge clk);
			if (!no_gaps) begin
				out_ready <= 1'b0;
				repeat (gap_len() + 1) @(negedge clk);
			end
		end
	end

	initial begin
		#2000000;
		$display("float_log2_unit_tb: FAIL");
		$finish;
	end

	initial begin
		logic [31:0] directed [];
		directed = '{
			32'h0000_0000, 32'h8000_0000, 32'h0000_0001, 32'h007f_ffff,
			32'h0080_0000, 32'h3f80_0000, 32'h4000_0000, 32'h3f00_0000,
			32'h3f35_04f2, 32'h3f35_04f3, 32'h3f35_04f4, 32'h3f7f_ffff,
			32'h7f7f_ffff, 32'h7f80_0000, 32'h7fff_ffff, 32'hffff_ffff,
			32'hbf80_0000, 32'hbf00_0000, 32'h4120_0000, 32'h3dcc_cccd
		};
		arst_n     = 1'b0;
		in_valid   = 1'b0;
		value_bits = 32'h0;
		no_gaps    = 1'b0;
		repeat (7) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		foreach (directed[i]) begin
			send_operand(directed[i]);
		end
		for (int n = 0; n < 1500; n++) begin
			if (n % 250 == 0) begin
				no_gaps = ($urandom_range(0, 2) == 0);
			end
			if (n == 700) begin
				// drain the pipe before carrying on
				@(negedge clk);
				in_valid <= 1'b0;
				while (pending != 0) @(negedge clk);
			end
			send_operand(random_operand());
		end
		@(negedge clk);
		in_valid <= 1'b0;
		no_gaps  = 1'b0;
		while (pending != 0) @(negedge clk);
		repeat (40) @(posedge clk);
		if (errors == 0) begin
			$display("float_log2_unit_tb: PASS");
		end else begin
			$display("float_log2_unit_tb: FAIL");
		end
		$finish;
	end

endmodule
